### hdl/tacs_pkg.sv
// Shared types and constants for the toggle-acknowledge chunk sender.
`timescale 1ns / 1ps
`default_nettype none

package tacs_pkg;

    // Fixed field widths of the stream words
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned WAIT_W    = 16;
    // Chunk byte count, wide enough for chunks of up to fifteen bytes
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    // Reset value of the miss limit register
    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd80;

    // Command codes of an input word
    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CONFIRM = 2'd3;

    // Sender mode codes, also reported as the status field
    localparam logic [STATUS_W-1:0] MODE_IDLE        = 3'd0;
    localparam logic [STATUS_W-1:0] MODE_SENDING     = 3'd1;
    localparam logic [STATUS_W-1:0] MODE_RESYNC      = 3'd2;
    localparam logic [STATUS_W-1:0] MODE_RESYNC_SEND = 3'd3;
    localparam logic [STATUS_W-1:0] MODE_WAIT_NEXT   = 3'd4;

    // One unit of work handed from the control stage to the output stage
    typedef struct packed {
        logic                is_write;
        logic [BYTE_W-1:0]   wr_index;
        logic [BYTE_W-1:0]   wr_value;
        logic [BYTE_W-1:0]   base_off;
        logic [CNT_W-1:0]    count;
        logic [BYTE_W-1:0]   pkg;
        logic [STATUS_W-1:0] status;
    } t_job;

endpackage

`default_nettype wire

### hdl/toggle_ack_chunk_sender.sv
// An accepted input word is held in the job register; each of its result words then passes
// through the result word register before it is offered. Throughput: one result word per
// cycle unless the output stalls; a word that yields one result can be taken every cycle, a
// payload request holds the input side until its bytes are read (one store read per cycle).
// Reset: synchronous, active low; clears the sender state and the limit register to 80.
// The message store is not cleared and holds unknown data until written.
`timescale 1ns / 1ps
`default_nettype none

module toggle_ack_chunk_sender #(
    parameter int unsigned BYTES_PER_CALL = 5,
    parameter int unsigned RESYNC_PACKAGE = 63,
    parameter int unsigned STORE_DEPTH    = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input words
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // byte_index [7:0], byte_value [15:8], msg_length [23:16], confirm_bit [24]
    input  wire logic [tacs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command [1:0]
    input  wire logic [tacs_pkg::CMD_W-1:0]        s_axis_tuser,
    // Result words
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // package_index [7:0], payload_byte [15:8], sender_active [16], sender_status [19:17]
    output logic [tacs_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // byte_valid [0]
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    // Limit register write
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tacs_pkg::WAIT_W-1:0]       i_cfg_data
);
    import tacs_pkg::*;

    t_job                w_job;
    logic                w_accept;
    logic [BYTE_W-1:0]   w_pkg;
    logic [BYTE_W-1:0]   w_byte;
    logic [STATUS_W-1:0] w_status;

    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Protocol state update
    tacs_ctrl #(
        .BYTES_PER_CALL (BYTES_PER_CALL),
        .RESYNC_PACKAGE (RESYNC_PACKAGE)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_command     (s_axis_tuser),
        .i_byte_index  (s_axis_tdata[7:0]),
        .i_byte_value  (s_axis_tdata[15:8]),
        .i_msg_length  (s_axis_tdata[23:16]),
        .i_confirm_bit (s_axis_tdata[24]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_job         (w_job)
    );

    // Store access and result words
    tacs_emit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_job        (w_job),
        .o_in_ready   (s_axis_tready),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_pkg        (w_pkg),
        .o_byte       (w_byte),
        .o_byte_valid (m_axis_tuser),
        .o_last       (m_axis_tlast),
        .o_status     (w_status)
    );

    assign m_axis_tdata = {4'b0000, w_status, (w_status != MODE_IDLE), w_byte, w_pkg};

endmodule

`default_nettype wire

### hdl/tacs_ctrl.sv
// Sender state machine: updates the protocol state for each accepted word.
`timescale 1ns / 1ps
`default_nettype none

module tacs_ctrl #(
    parameter int unsigned BYTES_PER_CALL = 5,
    parameter int unsigned RESYNC_PACKAGE = 63
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [tacs_pkg::CMD_W-1:0]    i_command,
    input  wire logic [tacs_pkg::BYTE_W-1:0]   i_byte_index,
    input  wire logic [tacs_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire logic [tacs_pkg::BYTE_W-1:0]   i_msg_length,
    input  wire logic                          i_confirm_bit,
    input  wire logic                          i_cfg_we,
    input  wire logic [tacs_pkg::WAIT_W-1:0]   i_cfg_data,
    output tacs_pkg::t_job                     o_job
);
    import tacs_pkg::*;

    logic [WAIT_W-1:0]   r_max_wait, n_max_wait;
    logic [STATUS_W-1:0] r_mode, n_mode;
    logic                r_toggle, n_toggle;
    logic [WAIT_W-1:0]   r_miss, n_miss;
    logic [BYTE_W-1:0]   r_len, n_len;
    logic [BYTE_W-1:0]   r_off, n_off;
    logic [BYTE_W-1:0]   r_pc, n_pc;
    logic [CNT_W-1:0]    r_lcb, n_lcb;

    logic [BYTE_W-1:0]   w_rem;
    logic [CNT_W-1:0]    w_cnt;
    logic [BYTE_W:0]     w_end;
    logic                w_final;
    logic [WAIT_W-1:0]   w_miss_inc;
    logic [BYTE_W-1:0]   w_off_adv;

    // Size of the chunk that a payload request would send now
    always_comb begin
        w_rem = r_len - r_off;
        if (w_rem < BYTE_W'(BYTES_PER_CALL)) begin
            w_cnt = w_rem[CNT_W-1:0];
        end else begin
            w_cnt = CNT_W'(BYTES_PER_CALL);
        end
        w_end   = {1'b0, r_off} + (BYTE_W+1)'(w_cnt);
        w_final = (r_pc > BYTE_W'(1)) && (w_end >= {1'b0, r_len});
    end

    assign w_miss_inc = r_miss + WAIT_W'(1);
    assign w_off_adv  = r_off + BYTE_W'(r_lcb);

    // Next state and the job for the output stage
    always_comb begin
        n_max_wait = r_max_wait;
        n_mode     = r_mode;
        n_toggle   = r_toggle;
        n_miss     = r_miss;
        n_len      = r_len;
        n_off      = r_off;
        n_pc       = r_pc;
        n_lcb      = r_lcb;

        o_job          = '0;
        o_job.wr_index = i_byte_index;
        o_job.wr_value = i_byte_value;
        o_job.base_off = r_off;

        if (i_cfg_we) begin
            n_max_wait = i_cfg_data;
        end

        if (i_accept) begin
            unique case (i_command)
                CMD_WRITE: begin
                    o_job.is_write = 1'b1;
                end
                CMD_START: begin
                    n_len  = i_msg_length;
                    n_off  = '0;
                    n_pc   = BYTE_W'(1);
                    n_miss = '0;
                    n_mode = (r_mode == MODE_IDLE) ? MODE_SENDING : MODE_RESYNC_SEND;
                end
                CMD_GET: begin
                    n_lcb = '0;
                    if (r_mode == MODE_RESYNC || r_mode == MODE_RESYNC_SEND) begin
                        o_job.pkg = BYTE_W'(RESYNC_PACKAGE);
                    end else if (r_mode == MODE_SENDING) begin
                        n_lcb       = w_cnt;
                        o_job.count = w_cnt;
                        o_job.pkg   = w_final ? '0 : r_pc;
                    end
                end
                CMD_CONFIRM: begin
                    unique case (r_mode)
                        MODE_SENDING: begin
                            if (i_confirm_bit != r_toggle) begin
                                n_miss = w_miss_inc;
                                if (w_miss_inc > r_max_wait) begin
                                    n_toggle = ~i_confirm_bit;
                                    n_mode   = MODE_RESYNC;
                                end
                            end else begin
                                n_off = w_off_adv;
                                if (w_off_adv >= r_len) begin
                                    n_mode = (r_pc == BYTE_W'(1)) ? MODE_WAIT_NEXT
                                                                  : MODE_IDLE;
                                end
                                n_pc     = r_pc + BYTE_W'(1);
                                n_toggle = ~r_toggle;
                                n_miss   = '0;
                            end
                        end
                        MODE_RESYNC, MODE_RESYNC_SEND, MODE_WAIT_NEXT: begin
                            if (i_confirm_bit == r_toggle) begin
                                n_mode   = (r_mode == MODE_RESYNC_SEND) ? MODE_SENDING
                                                                        : MODE_IDLE;
                                n_toggle = ~i_confirm_bit;
                            end else if (r_mode == MODE_WAIT_NEXT) begin
                                n_miss = w_miss_inc;
                                if (w_miss_inc > r_max_wait) begin
                                    n_toggle = ~i_confirm_bit;
                                    n_mode   = MODE_RESYNC;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        o_job.status = n_mode;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wait <= WAIT_RESET;
            r_mode     <= MODE_IDLE;
            r_toggle   <= 1'b1;
            r_miss     <= '0;
            r_len      <= '0;
            r_off      <= '0;
            r_pc       <= BYTE_W'(1);
            r_lcb      <= '0;
        end else begin
            r_max_wait <= n_max_wait;
            r_mode     <= n_mode;
            r_toggle   <= n_toggle;
            r_miss     <= n_miss;
            r_len      <= n_len;
            r_off      <= n_off;
            r_pc       <= n_pc;
            r_lcb      <= n_lcb;
        end
    end

endmodule

`default_nettype wire

### hdl/tacs_emit.sv
// Output stage: job register, message store and the result word register.
`timescale 1ns / 1ps
`default_nettype none

module tacs_emit #(
    parameter int unsigned STORE_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  tacs_pkg::t_job                     i_job,
    output logic                               o_in_ready,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [tacs_pkg::BYTE_W-1:0]        o_pkg,
    output logic [tacs_pkg::BYTE_W-1:0]        o_byte,
    output logic                               o_byte_valid,
    output logic                               o_last,
    output logic [tacs_pkg::STATUS_W-1:0]      o_status
);
    import tacs_pkg::*;

    localparam int unsigned AW    = $clog2(STORE_DEPTH);
    localparam int unsigned WRAPW = BYTE_W + 5;

    // Reduce a position modulo the store depth by conditional subtraction
    function automatic logic [AW-1:0] f_wrap(input logic [BYTE_W:0] v);
        logic [WRAPW-1:0] r;
        logic [WRAPW-1:0] d;
        int               k;
        r = WRAPW'(v);
        for (k = 4; k >= 0; k--) begin
            d = WRAPW'(STORE_DEPTH) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[AW-1:0];
    endfunction

    logic [BYTE_W-1:0] r_store [STORE_DEPTH];

    t_job              r_job;
    logic              r_job_v;
    logic [CNT_W-1:0]  r_idx;

    logic              r_out_v;
    logic [BYTE_W-1:0] r_pkg;
    logic [BYTE_W-1:0] r_rd;
    logic              r_bval;
    logic              r_last;
    logic [STATUS_W-1:0] r_status;

    logic              w_adv;
    logic              w_done;
    logic [AW-1:0]     w_raddr;
    logic [AW-1:0]     w_waddr;

    // One result leaves the job register whenever the output register frees up
    assign w_adv      = r_job_v && (!r_out_v || i_out_ready);
    assign w_done     = (r_job.count == '0) || ((r_idx + CNT_W'(1)) == r_job.count);
    assign o_in_ready = !r_job_v || (w_adv && w_done);
    assign w_raddr    = f_wrap({1'b0, r_job.base_off} + (BYTE_W+1)'(r_idx));
    assign w_waddr    = f_wrap({1'b0, r_job.wr_index});

    // Job register and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_idx   <= '0;
        end else if (o_in_ready && i_accept) begin
            r_job_v <= 1'b1;
            r_idx   <= '0;
        end else if (w_adv && w_done) begin
            r_job_v <= 1'b0;
        end else if (w_adv) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_accept) begin
            r_job <= i_job;
        end
    end

    // Message store: writes and reads happen in job order
    always_ff @(posedge i_clk) begin
        if (w_adv && r_job.is_write) begin
            r_store[w_waddr] <= r_job.wr_value;
        end
        if (w_adv && !r_job.is_write && (r_job.count != '0)) begin
            r_rd <= r_store[w_raddr];
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pkg    <= r_job.is_write ? '0 : r_job.pkg;
            r_bval   <= !r_job.is_write && (r_job.count != '0);
            r_last   <= w_done;
            r_status <= r_job.status;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_pkg        = r_pkg;
    assign o_byte       = r_bval ? r_rd : '0;
    assign o_byte_valid = r_bval;
    assign o_last       = r_last;
    assign o_status     = r_status;

endmodule

`default_nettype wire

### hdl/tacs_checker.sv
// Port-level checks on the result stream of the chunk sender, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tacs_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [tacs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                              m_axis_tuser,
    input  wire logic                              m_axis_tlast
);
    import tacs_pkg::*;

    // A word without a chunk byte carries a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:8] == 8'd0))
        else $error("payload byte not zero on a word without a chunk byte");

    // A word without a chunk byte is always the only result of its input
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("word without a chunk byte is not marked last");

    // The active flag follows the status field
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16] == (m_axis_tdata[19:17] != MODE_IDLE)))
        else $error("active flag disagrees with status");

    // Nothing is offered in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word offered straight after reset");

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind toggle_ack_chunk_sender tacs_checker u_tacs_checker (.*);

`default_nettype wire
